// ===== design/bilup_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear upscaler package
// Shared types, field widths, register indexes and step counts.
// ----------------------------------------------------------------------------
package bilup_pkg;

   localparam int COORD_W       = 12;
   localparam int CH_W          = 8;
   localparam int CSR_DATA_W    = 9;
   localparam int CSR_IDX_W     = 2;
   localparam int RATIO_FIELD_W = 5;

   localparam int SRC_DIM_RESET = 256;
   localparam int RATIO_RESET   = 7;
   localparam int CH_MAX        = 255;

   // sequencer step counts
   localparam int DIV_STEPS   = COORD_W;  // one quotient bit per step
   localparam int FETCH_STEPS = 5;        // four reads plus a trailing accumulate step
   localparam int QUO_STEPS   = CH_W;     // blended value always fits in a channel

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO      = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic ST_OK    = 1'b0;
   localparam logic ST_RANGE = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [CH_W-1:0]    in_red;
      logic [CH_W-1:0]    in_green;
      logic [CH_W-1:0]    in_blue;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] out_red;
      logic [CH_W-1:0] out_green;
      logic [CH_W-1:0] out_blue;
      logic            status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       check;
      logic       div_step;
      logic       wgt;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       acc_en;
      logic [1:0] acc_sel;
      logic       quo_step;
      logic       done;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_read;
      logic out_of_frame;
   } dp_sts_type;

endpackage

// ===== design/bilinear_upscaler_core.sv =====
// ----------------------------------------------------------------------------
// Bilinear upscaler core
// Integer-ratio bilinear upscaler over a stored RGB source frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : valid/ready item channel. cmd = write stores one source pixel at
//           (coord_x, coord_y); cmd = read returns the upscaled pixel at
//           output coordinate (coord_x, coord_y).
//   rsp_* : valid/ready result channel, exactly one result per item. Writes
//           return zero colors; status flags a coordinate outside the frame.
//   csr_* : write-only registers (src_width, src_height, ratio), written while
//           the core is idle. Out-of-range values saturate into 1..max.
// Sequence:
//   A read runs the two 12-step coordinate dividers, four fetches through
//   the single-port pixel memory and the 8-step divide by ratio squared;
//   writes and out-of-frame reads skip these. One item is worked on at a
//   time.
// Reset clears the control state and loads the register defaults; the pixel
// memory is not cleared, so reading a never-written pixel gives garbage.
// A stalled receiver is absorbed by the output register: the next item is
// accepted and worked on, and it waits only to deliver its own result.
// ----------------------------------------------------------------------------
module bilinear_upscaler_core import bilup_pkg::*; #(
   parameter int MAX_SRC_W = 256,
   parameter int MAX_SRC_H = 256,
   parameter int MAX_RATIO = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   rsp_type     rsp_next;
   logic        out_free;

   // output register: the result leaves the datapath here
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   bilup_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   bilup_dp #(
      .MAX_SRC_W (MAX_SRC_W),
      .MAX_SRC_H (MAX_SRC_H),
      .MAX_RATIO (MAX_RATIO)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_next  (rsp_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.done) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the controller only hands over a result when the output slot is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.done |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an undelivered one");

   // a flagged result carries no color
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_RANGE) |->
         (rsp_data.out_red == '0) && (rsp_data.out_green == '0) &&
         (rsp_data.out_blue == '0))
      else $error("out-of-frame result has nonzero color");

endmodule

// ===== design/bilup_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bilinear upscaler controller
// Sequences check, coordinate division, weights, fetches and blend division.
// ----------------------------------------------------------------------------
module bilup_ctrl import bilup_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_sts_type  sts,
   input  logic        out_free,
   output ctl_cmd_type cmd
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_DIV   = 7'b0000100,
      S_WGT   = 7'b0001000,
      S_FETCH = 7'b0010000,
      S_QUO   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cnt_dec;

   assign req_ready = (state_ff == S_IDLE);
   assign cnt_dec   = cnt_ff - CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = '0;
            if (sts.is_read && !sts.out_of_frame) begin
               state_in = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_WGT;
            end
         end
         S_WGT: begin
            cmd.wgt  = 1'b1;
            cnt_in   = '0;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            // read k issued at step k, its data accumulated at step k+1
            cmd.rd_en   = (cnt_ff != CNT_W'(FETCH_STEPS - 1));
            cmd.rd_sel  = cnt_ff[1:0];
            cmd.acc_en  = (cnt_ff != '0);
            cmd.acc_sel = cnt_dec[1:0];
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FETCH_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_QUO;
            end
         end
         S_QUO: begin
            cmd.quo_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QUO_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // one item in flight: no second accept right behind the first
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("controller accepted a second item back to back");

endmodule

// ===== design/bilup_dp.sv =====
// ----------------------------------------------------------------------------
// Bilinear upscaler datapath
// Config registers, pixel memory, serial dividers and blend accumulators.
// ----------------------------------------------------------------------------
module bilup_dp import bilup_pkg::*; #(
   parameter int MAX_SRC_W = 256,
   parameter int MAX_SRC_H = 256,
   parameter int MAX_RATIO = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  ctl_cmd_type           cmd,
   output dp_sts_type            sts,
   output rsp_type               rsp_next
);

   localparam int WW    = $clog2(MAX_SRC_W + 1);
   localparam int HW    = $clog2(MAX_SRC_H + 1);
   localparam int RW    = $clog2(MAX_RATIO + 1);
   localparam int CW    = $clog2(MAX_SRC_W);
   localparam int YW    = $clog2(MAX_SRC_H);
   localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int WTW   = 2 * RW;
   localparam int SW    = $clog2(MAX_RATIO * MAX_RATIO * CH_MAX + 1);
   localparam int OW    = WW + RW;
   localparam int OH    = HW + RW;
   localparam int PW    = WTW + CH_W;
   localparam int XPW   = (WW + RW > COORD_W) ? WW + RW : COORD_W;
   localparam int YPW   = (HW + RW > COORD_W) ? HW + RW : COORD_W;
   localparam int W_RST = (SRC_DIM_RESET > MAX_SRC_W) ? MAX_SRC_W : SRC_DIM_RESET;
   localparam int H_RST = (SRC_DIM_RESET > MAX_SRC_H) ? MAX_SRC_H : SRC_DIM_RESET;
   localparam int R_RST = (RATIO_RESET > MAX_RATIO) ? MAX_RATIO : RATIO_RESET;

   // ---------------- configuration ----------------
   logic [WW-1:0] src_width_ff, src_width_in;
   logic [HW-1:0] src_height_ff, src_height_in;
   logic [RW-1:0] ratio_ff, ratio_in;
   logic [RATIO_FIELD_W-1:0] ratio_wr;

   assign ratio_wr = csr_wdata[RATIO_FIELD_W-1:0];

   // zero saturates to one, above the maximum saturates to the maximum
   always_comb begin
      src_width_in  = (int'(csr_wdata) > MAX_SRC_W) ? WW'(MAX_SRC_W) : WW'(csr_wdata);
      src_height_in = (int'(csr_wdata) > MAX_SRC_H) ? HW'(MAX_SRC_H) : HW'(csr_wdata);
      ratio_in      = (int'(ratio_wr) > MAX_RATIO) ? RW'(MAX_RATIO) : RW'(ratio_wr);
      if (csr_wdata == '0) begin
         src_width_in  = WW'(1);
         src_height_in = HW'(1);
      end
      if (ratio_wr == '0) begin
         ratio_in = RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= WW'(W_RST);
         src_height_ff <= HW'(H_RST);
         ratio_ff      <= RW'(R_RST);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= src_width_in;
            CSR_SRC_HEIGHT: src_height_ff <= src_height_in;
            CSR_RATIO:      ratio_ff      <= ratio_in;
            default: ;
         endcase
      end
   end

   // ---------------- item and frame check ----------------
   req_type          item_ff;
   logic [WW+RW-1:0] out_w;
   logic [HW+RW-1:0] out_h;
   logic             is_read;
   logic             oof_rd;
   logic             oof_wr;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   assign out_w   = OW'(src_width_ff) * OW'(ratio_ff);
   assign out_h   = OH'(src_height_ff) * OH'(ratio_ff);
   assign is_read = (item_ff.cmd == CMD_READ);
   assign oof_rd  = (XPW'(item_ff.coord_x) >= XPW'(out_w)) ||
                    (YPW'(item_ff.coord_y) >= YPW'(out_h));
   assign oof_wr  = (XPW'(item_ff.coord_x) >= XPW'(src_width_ff)) ||
                    (YPW'(item_ff.coord_y) >= YPW'(src_height_ff));

   assign sts.is_read      = is_read;
   assign sts.out_of_frame = is_read ? oof_rd : oof_wr;

   // ---------------- coordinate dividers (restoring, 1 bit/cycle) ----------------
   logic [COORD_W-1:0] dqx_ff, dqx_in, dqy_ff, dqy_in;
   logic [RW-1:0]      remx_ff, remx_in, remy_ff, remy_in;
   logic [RW:0]        tx, ty;
   logic               gex, gey;

   always_comb begin
      tx      = {remx_ff, dqx_ff[COORD_W-1]};
      ty      = {remy_ff, dqy_ff[COORD_W-1]};
      gex     = (tx >= {1'b0, ratio_ff});
      gey     = (ty >= {1'b0, ratio_ff});
      remx_in = gex ? RW'(tx - {1'b0, ratio_ff}) : RW'(tx);
      remy_in = gey ? RW'(ty - {1'b0, ratio_ff}) : RW'(ty);
      dqx_in  = {dqx_ff[COORD_W-2:0], gex};
      dqy_in  = {dqy_ff[COORD_W-2:0], gey};
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         dqx_ff  <= item_ff.coord_x;
         dqy_ff  <= item_ff.coord_y;
         remx_ff <= '0;
         remy_ff <= '0;
      end else if (cmd.div_step) begin
         dqx_ff  <= dqx_in;
         dqy_ff  <= dqy_in;
         remx_ff <= remx_in;
         remy_ff <= remy_in;
      end
   end

   // ---------------- neighborhood and weights ----------------
   logic [CW-1:0]  sx, sx1;
   logic [YW-1:0]  sy, sy1;
   logic [WW-1:0]  sx_inc;
   logic [HW-1:0]  sy_inc;
   logic [RW-1:0]  ra, rb;
   logic [CW-1:0]  col_ff [2];
   logic [YW-1:0]  row_ff [2];
   logic [WTW-1:0] wgt_ff [4];
   logic [WTW-1:0] rr;
   logic [SW-1:0]  dsh_ff;

   always_comb begin
      sx     = CW'(dqx_ff);
      sy     = YW'(dqy_ff);
      sx_inc = WW'(sx) + WW'(1);
      sy_inc = HW'(sy) + HW'(1);
      // clamp the second neighbor at the right and bottom edges
      sx1    = (sx_inc < src_width_ff) ? CW'(sx_inc) : CW'(src_width_ff - WW'(1));
      sy1    = (sy_inc < src_height_ff) ? YW'(sy_inc) : YW'(src_height_ff - HW'(1));
      ra     = ratio_ff - remx_ff;
      rb     = ratio_ff - remy_ff;
      rr     = WTW'(ratio_ff) * WTW'(ratio_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.wgt) begin
         col_ff[0] <= sx;
         col_ff[1] <= sx1;
         row_ff[0] <= sy;
         row_ff[1] <= sy1;
         wgt_ff[0] <= WTW'(ra) * WTW'(rb);
         wgt_ff[1] <= WTW'(remx_ff) * WTW'(rb);
         wgt_ff[2] <= WTW'(ra) * WTW'(remy_ff);
         wgt_ff[3] <= WTW'(remx_ff) * WTW'(remy_ff);
      end
   end

   // ---------------- pixel memory, single port ----------------
   logic [3*CH_W-1:0] mem [DEPTH];
   logic [3*CH_W-1:0] rd_ff;
   logic [AW-1:0]     addr;
   logic [CW-1:0]     acol;
   logic [YW-1:0]     arow;
   logic              mem_we;

   assign mem_we = cmd.check && !is_read && !oof_wr;

   always_comb begin
      if (mem_we) begin
         acol = CW'(item_ff.coord_x);
         arow = YW'(item_ff.coord_y);
      end else begin
         acol = col_ff[cmd.rd_sel[0]];
         arow = row_ff[cmd.rd_sel[1]];
      end
      addr = AW'(arow) * AW'(MAX_SRC_W) + AW'(acol);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= {item_ff.in_red, item_ff.in_green, item_ff.in_blue};
      end else if (cmd.rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   // ---------------- blend accumulate and divide by ratio squared ----------------
   logic [SW-1:0]      acc_ff [3];
   logic [SW-1:0]      acc_in [3];
   logic [CH_W-1:0]    q_ff [3];
   logic [CH_W-1:0]    q_in [3];
   logic [WTW+CH_W-1:0] prod [3];
   logic [WTW-1:0]     w_sel;
   logic [CH_W-1:0]    chan [3];
   logic               ge [3];
   logic               status_ff;

   always_comb begin
      w_sel   = wgt_ff[cmd.acc_sel];
      chan[0] = rd_ff[3*CH_W-1:2*CH_W];
      chan[1] = rd_ff[2*CH_W-1:CH_W];
      chan[2] = rd_ff[CH_W-1:0];
      for (int i = 0; i < 3; i++) begin
         prod[i] = PW'(w_sel) * PW'(chan[i]);
         ge[i]   = (acc_ff[i] >= dsh_ff);
         if (cmd.acc_en) begin
            acc_in[i] = acc_ff[i] + SW'(prod[i]);
         end else begin
            acc_in[i] = ge[i] ? acc_ff[i] - dsh_ff : acc_ff[i];
         end
         q_in[i] = {q_ff[i][CH_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.wgt) begin
            acc_ff[i] <= '0;
         end else if (cmd.acc_en || cmd.quo_step) begin
            acc_ff[i] <= acc_in[i];
         end
         if (cmd.check) begin
            q_ff[i] <= '0;
         end else if (cmd.quo_step) begin
            q_ff[i] <= q_in[i];
         end
      end
      if (cmd.wgt) begin
         dsh_ff <= SW'(rr) << (QUO_STEPS - 1);
      end else if (cmd.quo_step) begin
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.check) begin
         status_ff <= sts.out_of_frame ? ST_RANGE : ST_OK;
      end
   end

   assign rsp_next.out_red   = q_ff[0];
   assign rsp_next.out_green = q_ff[1];
   assign rsp_next.out_blue  = q_ff[2];
   assign rsp_next.status    = status_ff;

   // a stored pixel always comes from an in-frame write with a clean zero result
   a_write_result: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> (status_ff == ST_OK) && (q_ff[0] == '0) && (q_ff[1] == '0) &&
                 (q_ff[2] == '0))
      else $error("pixel write left a nonzero or flagged result");

endmodule
